@@ design/rclf_pkg.sv @@
// shared types, constants and helpers for the command lease and feedback tracker
package rclf_pkg;

  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned TIME_W    = 64;
  localparam int unsigned SER_W     = 32;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_LEASE_MS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FB_MAX_MS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FB_COOL_MS  = 2'd2;

  localparam logic [CFG_W-1:0] LEASE_MS_RST   = 16'd1000;
  localparam logic [CFG_W-1:0] FB_MAX_MS_RST  = 16'd500;
  localparam logic [CFG_W-1:0] FB_COOL_MS_RST = 16'd1000;

  // opcode values
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_CMD  = 1'b1;

  localparam logic [SER_W-1:0] SERIAL_HALF = 32'h8000_0000;

  // queue between front and back, power of two
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic              opcode;
    logic [TIME_W-1:0] now_ms;
    logic [SER_W-1:0]  session_id;
    logic [SER_W-1:0]  sequence_req;
    logic [SER_W-1:0]  feedback_serial;
    logic [SER_W-1:0]  press_duration_ms;
    logic              laser_request;
    logic              servo_en;
  } in_word_t;

  typedef struct packed {
    logic accepted;
    logic lease_active;
    logic laser_on;
    logic press_active;
  } out_word_t;

  // classified word handed from front to back
  typedef struct packed {
    logic              is_cmd;
    logic [TIME_W-1:0] now_ms;
    logic [SER_W-1:0]  session_id;
    logic [SER_W-1:0]  sequence_req;
    logic [SER_W-1:0]  feedback_serial;
    logic              fb_nonzero;
    logic              dur_nonzero;
    logic              laser_request;
    logic              servo_en;
    logic [TIME_W-1:0] press_end;
    logic [TIME_W-1:0] cool_end;
  } cls_word_t;

  // serial compare modulo 2^32
  function automatic logic is_newer(input logic [SER_W-1:0] cand,
                                    input logic [SER_W-1:0] prev);
    logic [SER_W-1:0] d;
    d = cand - prev;
    return (d != '0) && (d < SERIAL_HALF);
  endfunction

endpackage

@@ design/rclf_front.sv @@
// front end: takes input words, clamps the press and precomputes end times
module rclf_front (
  input  logic                             in_valid,
  output logic                             in_stall,
  input  rclf_pkg::in_word_t               in_word,
  input  logic [rclf_pkg::CFG_W-1:0]       fb_max_ms,
  input  logic [rclf_pkg::CFG_W-1:0]       fb_cool_ms,
  input  logic                             q_full,
  output logic                             q_push,
  output rclf_pkg::cls_word_t              q_wdata
);

  logic [rclf_pkg::CFG_W-1:0]    dur_c;
  logic [rclf_pkg::CFG_W:0]      dur_cool;
  logic [rclf_pkg::TIME_W:0]     pe_sum;
  logic [rclf_pkg::TIME_W:0]     ce_sum;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // clamp to the configured maximum
  assign dur_c = (in_word.press_duration_ms > {16'd0, fb_max_ms}) ?
                 fb_max_ms : in_word.press_duration_ms[rclf_pkg::CFG_W-1:0];
  assign dur_cool = {1'b0, dur_c} + {1'b0, fb_cool_ms};

  // saturating end times; a saturated press end implies a saturated cooldown end
  assign pe_sum = {1'b0, in_word.now_ms} + {49'd0, dur_c};
  assign ce_sum = {1'b0, in_word.now_ms} + {48'd0, dur_cool};

  always_comb begin
    q_wdata.is_cmd          = (in_word.opcode == rclf_pkg::OP_CMD);
    q_wdata.now_ms          = in_word.now_ms;
    q_wdata.session_id      = in_word.session_id;
    q_wdata.sequence_req    = in_word.sequence_req;
    q_wdata.feedback_serial = in_word.feedback_serial;
    q_wdata.fb_nonzero      = (in_word.feedback_serial != '0);
    q_wdata.dur_nonzero     = (in_word.press_duration_ms != '0);
    q_wdata.laser_request   = in_word.laser_request;
    q_wdata.servo_en        = in_word.servo_en;
    q_wdata.press_end       = pe_sum[rclf_pkg::TIME_W] ? '1 : pe_sum[rclf_pkg::TIME_W-1:0];
    q_wdata.cool_end        = ce_sum[rclf_pkg::TIME_W] ? '1 : ce_sum[rclf_pkg::TIME_W-1:0];
  end

endmodule

@@ design/rclf_queue.sv @@
// short queue of classified words between front and back
module rclf_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  rclf_pkg::cls_word_t  wdata,
  input  logic                 pop,
  output rclf_pkg::cls_word_t  rdata,
  output logic                 not_empty,
  output logic                 full
);

  localparam int unsigned PTR_W = $clog2(rclf_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(rclf_pkg::QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(rclf_pkg::QUEUE_DEPTH);

  rclf_pkg::cls_word_t     slot_r [rclf_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;

  assign not_empty = (count_r != '0);
  assign full      = (count_r == DEPTH_C);
  assign rdata     = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

@@ design/rclf_back.sv @@
// back end: lease, session and press state, plus the result register
module rclf_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [rclf_pkg::CFG_W-1:0]  lease_ms,
  input  rclf_pkg::cls_word_t         q_rdata,
  input  logic                        q_not_empty,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output rclf_pkg::out_word_t         out_word
);

  logic                          known_r, known_nxt;
  logic [rclf_pkg::SER_W-1:0]    cur_sess_r, cur_sess_nxt;
  logic [rclf_pkg::SER_W-1:0]    last_seq_r, last_seq_nxt;
  logic [rclf_pkg::SER_W-1:0]    last_fb_r, last_fb_nxt;
  logic                          leased_r, leased_nxt;
  logic                          laser_r, laser_nxt;
  logic                          press_r, press_nxt;
  logic [rclf_pkg::TIME_W-1:0]   press_end_r, press_end_nxt;
  logic [rclf_pkg::TIME_W-1:0]   cool_end_r, cool_end_nxt;
  logic [rclf_pkg::TIME_W-1:0]   last_cmd_r, last_cmd_nxt;
  logic                          out_valid_r, out_valid_nxt;
  rclf_pkg::out_word_t           out_word_r, out_word_nxt;

  logic [rclf_pkg::TIME_W-1:0]   elapsed;
  logic                          lease_exp;
  logic                          leased1, laser1, press1, press2;
  logic [rclf_pkg::TIME_W-1:0]   pend1;
  logic                          fresh, stale, take, reconnect;
  logic [rclf_pkg::SER_W-1:0]    fb_base;
  logic                          fb_new, press_base, start;

  assign q_pop     = q_not_empty && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_comb begin
    // expiry checks run on every word
    elapsed   = q_rdata.now_ms - last_cmd_r;
    lease_exp = leased_r && (elapsed >= {48'd0, lease_ms});
    leased1   = leased_r && !lease_exp;
    laser1    = laser_r && !lease_exp;
    press1    = press_r && !lease_exp;
    pend1     = lease_exp ? '0 : press_end_r;
    press2    = press1 && !(q_rdata.now_ms >= pend1);

    // command classification against the session
    fresh = !known_r || (cur_sess_r != q_rdata.session_id);
    stale = !fresh && (q_rdata.sequence_req != last_seq_r) &&
            !rclf_pkg::is_newer(q_rdata.sequence_req, last_seq_r);
    take      = q_rdata.is_cmd && !stale;
    reconnect = fresh || !leased1;

    fb_base    = fresh ? '0 : last_fb_r;
    press_base = fresh ? 1'b0 : press2;
    fb_new     = q_rdata.fb_nonzero &&
                 ((fb_base == '0) || rclf_pkg::is_newer(q_rdata.feedback_serial, fb_base));
    start      = fb_new && !reconnect && q_rdata.servo_en && !press_base &&
                 (q_rdata.now_ms >= cool_end_r) && q_rdata.dur_nonzero;

    known_nxt     = known_r;
    cur_sess_nxt  = cur_sess_r;
    last_seq_nxt  = last_seq_r;
    last_fb_nxt   = last_fb_r;
    leased_nxt    = leased_r;
    laser_nxt     = laser_r;
    press_nxt     = press_r;
    press_end_nxt = press_end_r;
    cool_end_nxt  = cool_end_r;
    last_cmd_nxt  = last_cmd_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;

    if (q_pop) begin
      if (take) begin
        known_nxt     = 1'b1;
        cur_sess_nxt  = q_rdata.session_id;
        last_seq_nxt  = q_rdata.sequence_req;
        last_fb_nxt   = fb_new ? q_rdata.feedback_serial : fb_base;
        leased_nxt    = 1'b1;
        laser_nxt     = q_rdata.laser_request;
        press_nxt     = start || press_base;
        press_end_nxt = start ? q_rdata.press_end : (fresh ? '0 : pend1);
        cool_end_nxt  = start ? q_rdata.cool_end : cool_end_r;
        last_cmd_nxt  = q_rdata.now_ms;
      end else begin
        leased_nxt    = leased1;
        laser_nxt     = laser1;
        press_nxt     = press2;
        press_end_nxt = pend1;
      end
      out_valid_nxt             = 1'b1;
      out_word_nxt.accepted     = take;
      out_word_nxt.lease_active = leased_nxt;
      out_word_nxt.laser_on     = laser_nxt;
      out_word_nxt.press_active = press_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      known_r     <= 1'b0;
      cur_sess_r  <= '0;
      last_seq_r  <= '0;
      last_fb_r   <= '0;
      leased_r    <= 1'b0;
      laser_r     <= 1'b0;
      press_r     <= 1'b0;
      press_end_r <= '0;
      cool_end_r  <= '0;
      last_cmd_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      known_r     <= known_nxt;
      cur_sess_r  <= cur_sess_nxt;
      last_seq_r  <= last_seq_nxt;
      last_fb_r   <= last_fb_nxt;
      leased_r    <= leased_nxt;
      laser_r     <= laser_nxt;
      press_r     <= press_nxt;
      press_end_r <= press_end_nxt;
      cool_end_r  <= cool_end_nxt;
      last_cmd_r  <= last_cmd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

endmodule

@@ design/remote_command_lease_feedback.sv @@
// top level of the remote command lease and feedback press tracker
// Takes one word per cycle while in_stall is low, tick or command, each
// stamped with a millisecond time, and returns one result word per input
// word in order. Throughput is one word per clock without result stalls;
// an accepted word passes the queue and then the result register. The front
// classifies a word in the cycle it is accepted (clamps the press duration,
// precomputes saturating press and cooldown end times) and writes it to a
// two-entry queue; the back pops one word per cycle without result stalls,
// runs the lease and press expiry, the session and serial checks and the
// state update, and loads the result register. The back's per-word update
// (a 64-bit elapsed-time subtract and compare next to two 64-bit time
// compares) sets the clock period. in_stall rises only when the queue is
// full, which happens only while the result side stalls. Configuration
// registers must be written through cfg_we/cfg_index/cfg_data only while no
// word is in flight (not enforced by the block); an unknown index is ignored.
module remote_command_lease_feedback (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  rclf_pkg::in_word_t                  in_word,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output rclf_pkg::out_word_t                 out_word,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [rclf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rclf_pkg::CFG_W-1:0]          cfg_data
);

  // configuration registers
  logic [rclf_pkg::CFG_W-1:0] lease_ms_r, lease_ms_nxt;
  logic [rclf_pkg::CFG_W-1:0] fb_max_r, fb_max_nxt;
  logic [rclf_pkg::CFG_W-1:0] fb_cool_r, fb_cool_nxt;

  // queue hookup
  logic                q_push, q_pop, q_full, q_not_empty;
  rclf_pkg::cls_word_t q_wdata, q_rdata;

  // register decode, unknown index falls through
  always_comb begin
    lease_ms_nxt = lease_ms_r;
    fb_max_nxt   = fb_max_r;
    fb_cool_nxt  = fb_cool_r;
    if (cfg_we) begin
      unique case (cfg_index)
        rclf_pkg::CFG_LEASE_MS:   lease_ms_nxt = cfg_data;
        rclf_pkg::CFG_FB_MAX_MS:  fb_max_nxt   = cfg_data;
        rclf_pkg::CFG_FB_COOL_MS: fb_cool_nxt  = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lease_ms_r <= rclf_pkg::LEASE_MS_RST;
      fb_max_r   <= rclf_pkg::FB_MAX_MS_RST;
      fb_cool_r  <= rclf_pkg::FB_COOL_MS_RST;
    end else begin
      lease_ms_r <= lease_ms_nxt;
      fb_max_r   <= fb_max_nxt;
      fb_cool_r  <= fb_cool_nxt;
    end
  end

  // front: accept and classify
  rclf_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .fb_max_ms  (fb_max_r),
    .fb_cool_ms (fb_cool_r),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_wdata    (q_wdata)
  );

  // decoupling queue
  rclf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .pop       (q_pop),
    .rdata     (q_rdata),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  // back: state update and result register
  rclf_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .lease_ms    (lease_ms_r),
    .q_rdata     (q_rdata),
    .q_not_empty (q_not_empty),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word)
  );

endmodule

@@ design/rclf_checker.sv @@
// port-level checks for the tracker, bound to the top level
module rclf_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input rclf_pkg::out_word_t out_word
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word changed under stall");

  // an accepted command always leaves the lease live
  a_acc_lease: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.accepted |-> out_word.lease_active)
    else $error("accepted command without lease");

  // a press only runs under a live lease
  a_press_lease: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.press_active |-> out_word.lease_active)
    else $error("press active without lease");

  // disconnect drops the laser with the lease
  a_laser_lease: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.laser_on |-> out_word.lease_active)
    else $error("laser on without lease");

endmodule

bind remote_command_lease_feedback rclf_checker u_rclf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
